@@ hdl/qte_pkg.sv @@
// shared types, constants and helpers for the quaternion to euler offset block
package qte_pkg;

  localparam int QW     = 16;  // quaternion component width, Q1.14
  localparam int TW     = 32;  // translation width, Q16.16
  localparam int AW     = 15;  // angle bias width, Q2.12
  localparam int OW     = 16;  // angle result width, Q3.12
  localparam int PW     = 32;  // product width
  localparam int OPW    = 36;  // atan2 operand width
  localparam int CW     = 38;  // cordic x and y width, room for gain
  localparam int ZW     = 36;  // cordic angle accumulator width, scaled 2^30
  localparam int NW     = 62;  // root radicand width
  localparam int SQ_STEPS = NW / 2;
  localparam int RTW    = SQ_STEPS;
  localparam int REMW   = 36;
  localparam int ANGW   = ZW + 1;

  localparam logic signed [OPW-1:0] ONE_Q28     = 36'sd268435456;
  localparam logic signed [ZW-1:0]  PI_Q30      = 36'sd3373259426;
  localparam logic signed [ANGW-1:0] HALF_PI_Q30 = 37'sd1686629713;
  localparam logic signed [ANGW-1:0] ROUND_Q12  = 37'sd131072;

  localparam logic [31:0] ATAN_TAB [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

  typedef enum logic [2:0] {
    REG_OFF_X     = 3'd0,
    REG_OFF_Y     = 3'd1,
    REG_OFF_Z     = 3'd2,
    REG_OFF_ROLL  = 3'd3,
    REG_OFF_PITCH = 3'd4,
    REG_OFF_YAW   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic signed [OPW-1:0] y;
    logic signed [OPW-1:0] x;
  } vec_t;

  typedef struct packed {
    logic signed [TW-1:0] x;
    logic signed [TW-1:0] y;
    logic signed [TW-1:0] z;
  } pos_t;

  function automatic logic signed [TW-1:0] sat_add32(input logic signed [TW-1:0] a,
                                                     input logic signed [TW-1:0] b);
    logic signed [TW:0] s;
    s = {a[TW-1], a} + {b[TW-1], b};
    if (s[TW] != s[TW-1]) begin
      sat_add32 = s[TW] ? {1'b1, {(TW-1){1'b0}}} : {1'b0, {(TW-1){1'b1}}};
    end else begin
      sat_add32 = s[TW-1:0];
    end
  endfunction

endpackage

@@ hdl/qte_front.sv @@
// front end: quaternion products, atan2 operands, root radicands and biased translation
module qte_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  logic signed [qte_pkg::QW-1:0] qw_i,
  input  logic signed [qte_pkg::QW-1:0] qx_i,
  input  logic signed [qte_pkg::QW-1:0] qy_i,
  input  logic signed [qte_pkg::QW-1:0] qz_i,
  input  qte_pkg::pos_t                 trans_i,
  input  qte_pkg::pos_t                 off_i,
  output logic                          vld_o,
  output qte_pkg::vec_t                 roll_o,
  output qte_pkg::vec_t                 yaw_o,
  output logic [qte_pkg::NW-1:0]        na_o,
  output logic [qte_pkg::NW-1:0]        nb_o,
  output qte_pkg::pos_t                 pos_o
);
  import qte_pkg::*;

  logic                 vld1_r;
  logic signed [PW-1:0] p_wx_r, p_yz_r, p_xx_r, p_yy_r, p_wz_r, p_xy_r, p_zz_r, p_wy_r, p_xz_r;
  pos_t                 pos1_r;

  logic signed [OPW-1:0] e_wx, e_yz, e_xx, e_yy, e_wz, e_xy, e_zz, e_wy, e_xz;
  logic signed [OPW-1:0] pa, pb;
  vec_t                  roll_nxt, yaw_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
      vld_o  <= 1'b0;
    end else if (en) begin
      vld1_r <= vld_i;
      vld_o  <= vld1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_wx_r   <= qw_i * qx_i;
      p_yz_r   <= qy_i * qz_i;
      p_xx_r   <= qx_i * qx_i;
      p_yy_r   <= qy_i * qy_i;
      p_wz_r   <= qw_i * qz_i;
      p_xy_r   <= qx_i * qy_i;
      p_zz_r   <= qz_i * qz_i;
      p_wy_r   <= qw_i * qy_i;
      p_xz_r   <= qx_i * qz_i;
      pos1_r.x <= sat_add32(trans_i.x, off_i.x);
      pos1_r.y <= sat_add32(trans_i.y, off_i.y);
      pos1_r.z <= sat_add32(trans_i.z, off_i.z);
    end
  end

  always_comb begin
    e_wx = OPW'(p_wx_r);
    e_yz = OPW'(p_yz_r);
    e_xx = OPW'(p_xx_r);
    e_yy = OPW'(p_yy_r);
    e_wz = OPW'(p_wz_r);
    e_xy = OPW'(p_xy_r);
    e_zz = OPW'(p_zz_r);
    e_wy = OPW'(p_wy_r);
    e_xz = OPW'(p_xz_r);
    roll_nxt.y = (e_wx + e_yz) <<< 1;
    roll_nxt.x = ONE_Q28 - ((e_xx + e_yy) <<< 1);
    yaw_nxt.y  = (e_wz + e_xy) <<< 1;
    yaw_nxt.x  = ONE_Q28 - ((e_yy + e_zz) <<< 1);
    pa = ONE_Q28 + ((e_wy - e_xz) <<< 1);
    pb = ONE_Q28 - ((e_wy - e_xz) <<< 1);
  end

  // negative radicands clamp to zero, then scale by 2^28
  always_ff @(posedge clk) begin
    if (en) begin
      roll_o <= roll_nxt;
      yaw_o  <= yaw_nxt;
      na_o   <= pa[OPW-1] ? '0 : {pa[NW-29:0], 28'b0};
      nb_o   <= pb[OPW-1] ? '0 : {pb[NW-29:0], 28'b0};
      pos_o  <= pos1_r;
    end
  end

endmodule

@@ hdl/qte_sqrt.sv @@
// pipelined integer square root, one result bit per stage
module qte_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    vld_i,
  input  logic [qte_pkg::NW-1:0]  n_i,
  output logic                    vld_o,
  output logic [qte_pkg::RTW-1:0] root_o
);
  import qte_pkg::*;

  logic [REMW-1:0] rem_r  [SQ_STEPS];
  logic [RTW-1:0]  root_r [SQ_STEPS];
  logic [NW-1:0]   n_r    [SQ_STEPS];
  logic            vld_r  [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [REMW-1:0] rem_p, rem_sh, trial;
    logic [RTW-1:0]  root_p;
    logic [NW-1:0]   n_p;
    logic            vld_p;

    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign root_p = '0;
      assign n_p    = n_i;
      assign vld_p  = vld_i;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign root_p = root_r[k-1];
      assign n_p    = n_r[k-1];
      assign vld_p  = vld_r[k-1];
    end

    assign rem_sh = {rem_p[REMW-3:0], n_p[2*(SQ_STEPS-1-k)+1 -: 2]};
    assign trial  = REMW'({root_p, 2'b01});

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        n_r[k] <= n_p;
        if (rem_sh >= trial) begin
          rem_r[k]  <= rem_sh - trial;
          root_r[k] <= {root_p[RTW-2:0], 1'b1};
        end else begin
          rem_r[k]  <= rem_sh;
          root_r[k] <= {root_p[RTW-2:0], 1'b0};
        end
      end
    end
  end

  assign vld_o  = vld_r[SQ_STEPS-1];
  assign root_o = root_r[SQ_STEPS-1];

endmodule

@@ hdl/qte_delay.sv @@
// enabled shift line that keeps side data in step with the pipeline
module qte_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 4
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] d_o
);

  logic [W-1:0] sh_r [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sh_r[0] <= d_i;
      for (int i = 1; i < DEPTH; i++) begin
        sh_r[i] <= sh_r[i-1];
      end
    end
  end

  assign d_o = sh_r[DEPTH-1];

endmodule

@@ hdl/qte_cordic.sv @@
// pipelined vectoring cordic atan2, angle scaled by 2^30
module qte_cordic #(
  parameter int STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          en,
  input  logic                          vld_i,
  input  qte_pkg::vec_t                 v_i,
  output logic                          vld_o,
  output logic signed [qte_pkg::ZW-1:0] z_o
);
  import qte_pkg::*;

  logic signed [CW-1:0] x_r    [STAGES+1];
  logic signed [CW-1:0] y_r    [STAGES+1];
  logic signed [ZW-1:0] z_r    [STAGES+1];
  logic                 zero_r [STAGES+1];
  logic                 vld_r  [STAGES+1];

  logic signed [CW-1:0] x_in, y_in;

  assign x_in = CW'(v_i.x);
  assign y_in = CW'(v_i.y);

  // left half plane folds over, angle starts at +-pi
  always_ff @(posedge clk) begin
    if (en) begin
      zero_r[0] <= (x_in == '0) && (y_in == '0);
      if (x_in < 0) begin
        x_r[0] <= -x_in;
        y_r[0] <= -y_in;
        z_r[0] <= (y_in >= 0) ? PI_Q30 : -PI_Q30;
      end else begin
        x_r[0] <= x_in;
        y_r[0] <= y_in;
        z_r[0] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    logic signed [CW-1:0] dx, dy;
    logic signed [ZW-1:0] da;

    assign dx = y_r[i] >>> i;
    assign dy = x_r[i] >>> i;
    assign da = ZW'(ATAN_TAB[i]);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (en) begin
        vld_r[i+1] <= vld_r[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        zero_r[i+1] <= zero_r[i];
        if (y_r[i] > 0) begin
          x_r[i+1] <= x_r[i] + dx;
          y_r[i+1] <= y_r[i] - dy;
          z_r[i+1] <= z_r[i] + da;
        end else begin
          x_r[i+1] <= x_r[i] - dx;
          y_r[i+1] <= y_r[i] + dy;
          z_r[i+1] <= z_r[i] - da;
        end
      end
    end
  end

  assign vld_o = vld_r[STAGES];
  assign z_o   = zero_r[STAGES] ? '0 : z_r[STAGES];

endmodule

@@ hdl/quaternion_to_euler_offset.sv @@
// top level: quaternion pose to biased euler angles and biased translation
//
//  channel | ports                                  | direction
//  in      | in_valid, in_ready, in_quat_*, in_trans_* | pose in
//  out     | out_valid, out_ready, out_pos_*, out_*_out | pose out
//  cfg     | cfg_we, cfg_addr, cfg_wdata            | bias writes
//
// one item per cycle while out_ready is high or the output holds no valid result;
// the 31-step root pipeline is followed by the cordic pipeline
// all stages move together; a held result at the output stops the whole pipe
// and in_ready stays low for as long as that result is held
// synchronous active-low reset clears valid bits and the bias registers
module quaternion_to_euler_offset #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [qte_pkg::QW-1:0] in_quat_w,
  input  logic signed [qte_pkg::QW-1:0] in_quat_x,
  input  logic signed [qte_pkg::QW-1:0] in_quat_y,
  input  logic signed [qte_pkg::QW-1:0] in_quat_z,
  input  logic signed [qte_pkg::TW-1:0] in_trans_x,
  input  logic signed [qte_pkg::TW-1:0] in_trans_y,
  input  logic signed [qte_pkg::TW-1:0] in_trans_z,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [qte_pkg::TW-1:0] out_pos_x,
  output logic signed [qte_pkg::TW-1:0] out_pos_y,
  output logic signed [qte_pkg::TW-1:0] out_pos_z,
  output logic signed [qte_pkg::OW-1:0] out_roll_out,
  output logic signed [qte_pkg::OW-1:0] out_pitch_out,
  output logic signed [qte_pkg::OW-1:0] out_yaw_out,
  input  logic                          cfg_we,
  input  logic [2:0]                    cfg_addr,
  input  logic [qte_pkg::TW-1:0]        cfg_wdata
);
  import qte_pkg::*;

  localparam int POS_DEPTH = SQ_STEPS + 1 + CORDIC_STAGES;

  pos_t                 off_r;
  logic signed [AW-1:0] off_roll_r, off_pitch_r, off_yaw_r;

  logic                 en;
  logic                 f_vld, sa_vld, c_vld;
  vec_t                 f_roll, f_yaw, d_roll, d_yaw, p_vec;
  logic [NW-1:0]        f_na, f_nb;
  logic [RTW-1:0]       rs, rc;
  pos_t                 trans, f_pos, d_pos;
  logic signed [ZW-1:0] z_roll, z_pitch, z_yaw;
  logic signed [ANGW-1:0] a_roll, a_pitch, a_yaw;
  logic signed [ANGW-1:0] r_roll, r_pitch, r_yaw;

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r       <= '0;
      off_roll_r  <= '0;
      off_pitch_r <= '0;
      off_yaw_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_OFF_X:     off_r.x     <= cfg_wdata;
        REG_OFF_Y:     off_r.y     <= cfg_wdata;
        REG_OFF_Z:     off_r.z     <= cfg_wdata;
        REG_OFF_ROLL:  off_roll_r  <= cfg_wdata[AW-1:0];
        REG_OFF_PITCH: off_pitch_r <= cfg_wdata[AW-1:0];
        REG_OFF_YAW:   off_yaw_r   <= cfg_wdata[AW-1:0];
        default: ;
      endcase
    end
  end

  assign trans.x = in_trans_x;
  assign trans.y = in_trans_y;
  assign trans.z = in_trans_z;

  qte_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .vld_i   (in_valid),
    .qw_i    (in_quat_w),
    .qx_i    (in_quat_x),
    .qy_i    (in_quat_y),
    .qz_i    (in_quat_z),
    .trans_i (trans),
    .off_i   (off_r),
    .vld_o   (f_vld),
    .roll_o  (f_roll),
    .yaw_o   (f_yaw),
    .na_o    (f_na),
    .nb_o    (f_nb),
    .pos_o   (f_pos)
  );

  qte_sqrt u_sqrt_a (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (f_vld),
    .n_i    (f_na),
    .vld_o  (sa_vld),
    .root_o (rs)
  );

  qte_sqrt u_sqrt_b (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (f_vld),
    .n_i    (f_nb),
    .vld_o  (),
    .root_o (rc)
  );

  qte_delay #(.W($bits(vec_t)), .DEPTH(SQ_STEPS)) u_dly_roll (
    .clk (clk),
    .en  (en),
    .d_i (f_roll),
    .d_o (d_roll)
  );

  qte_delay #(.W($bits(vec_t)), .DEPTH(SQ_STEPS)) u_dly_yaw (
    .clk (clk),
    .en  (en),
    .d_i (f_yaw),
    .d_o (d_yaw)
  );

  qte_delay #(.W($bits(pos_t)), .DEPTH(POS_DEPTH)) u_dly_pos (
    .clk (clk),
    .en  (en),
    .d_i (f_pos),
    .d_o (d_pos)
  );

  assign p_vec.y = OPW'(rs);
  assign p_vec.x = OPW'(rc);

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_pitch (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (sa_vld),
    .v_i   (p_vec),
    .vld_o (c_vld),
    .z_o   (z_pitch)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_roll (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (sa_vld),
    .v_i   (d_roll),
    .vld_o (),
    .z_o   (z_roll)
  );

  qte_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_yaw (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (en),
    .vld_i (sa_vld),
    .v_i   (d_yaw),
    .vld_o (),
    .z_o   (z_yaw)
  );

  // pitch is twice the half-angle minus pi/2, then all round half up to q3.12
  always_comb begin
    a_roll  = ANGW'(z_roll);
    a_yaw   = ANGW'(z_yaw);
    a_pitch = (ANGW'(z_pitch) <<< 1) - HALF_PI_Q30;
    r_roll  = (a_roll + ROUND_Q12) >>> 18;
    r_pitch = (a_pitch + ROUND_Q12) >>> 18;
    r_yaw   = (a_yaw + ROUND_Q12) >>> 18;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= c_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pos_x     <= d_pos.x;
      out_pos_y     <= d_pos.y;
      out_pos_z     <= d_pos.z;
      out_roll_out  <= r_roll[OW-1:0] + OW'(off_roll_r);
      out_pitch_out <= r_pitch[OW-1:0] + OW'(off_pitch_r);
      out_yaw_out   <= r_yaw[OW-1:0] + OW'(off_yaw_r);
    end
  end

endmodule
